// ----- rtl/core/zero_cross_phase_dimmer_top_defines.svh -----
// Assertion macros for the zero-cross phase dimmer.
// Used by the top level; expects clk and rst in scope.
`ifndef ZERO_CROSS_PHASE_DIMMER_TOP_DEFINES_SVH
`define ZERO_CROSS_PHASE_DIMMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ZCPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zcpd: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ZCPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zcpd: next-cycle check failed");

`endif

// ----- rtl/core/zcpd_pkg.sv -----
// Shared types, constants and helper functions for the zero-cross phase dimmer.
// No dependencies.
`timescale 1ns / 1ps

package zcpd_pkg;

  localparam int ELAPSED_WIDTH = 20;
  localparam int COUNT_WIDTH   = 32;
  localparam int CFG_W         = 16;
  localparam int AVG_W         = 16;
  localparam int PCT_W         = 7;
  localparam int INDEX_W       = 3;
  localparam int RESULT_CNT_W  = 32;

  localparam logic [AVG_W-1:0] DEFAULT_HALF_CYCLE = 16'd10000;
  localparam logic [ELAPSED_WIDTH-1:0] ELAPSED_MAX = '1;

  // 7*avg + elapsed is accumulated 32 bits wide, then divided by 8
  localparam int AVG_SUM_W = 32;

  // eg + gpw + mfd, three 16-bit values
  localparam int OFFSET_W = CFG_W + 2;
  localparam int WINDOW_W = OFFSET_W + 1;

  // floor(x/100) as (x * ceil(2^30/100)) >> 30, exact for x < 2^23
  localparam int PCT_DIVISOR  = 100;
  localparam int RECIP_SHIFT  = 30;
  localparam int FACTOR_W     = 30;
  localparam int PROD_W       = AVG_W + FACTOR_W;
  localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_SHIFT;
  localparam logic [FACTOR_W-1:0] RECIP_100 =
    FACTOR_W'((RECIP_ONE + 64'(PCT_DIVISOR) - 64'd1) / 64'(PCT_DIVISOR));
  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(PCT_DIVISOR);

  // Config register reset values
  localparam logic            RST_TRIGGER_LEVEL = 1'b0;
  localparam logic [CFG_W-1:0] RST_DEBOUNCE     = 16'd4000;
  localparam logic [CFG_W-1:0] RST_MIN_HALF     = 16'd7000;
  localparam logic [CFG_W-1:0] RST_MAX_HALF     = 16'd12000;
  localparam logic [CFG_W-1:0] RST_MIN_FIRE     = 16'd300;
  localparam logic [CFG_W-1:0] RST_END_GUARD    = 16'd700;
  localparam logic [CFG_W-1:0] RST_PULSE_WIDTH  = 16'd500;

  typedef enum logic [INDEX_W-1:0] {
    CFG_TRIGGER_LEVEL    = 3'd0,
    CFG_DEBOUNCE_TICKS   = 3'd1,
    CFG_MIN_HALF_CYCLE   = 3'd2,
    CFG_MAX_HALF_CYCLE   = 3'd3,
    CFG_MIN_FIRE_DELAY   = 3'd4,
    CFG_END_GUARD        = 3'd5,
    CFG_GATE_PULSE_WIDTH = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic                trigger_level;
    logic [CFG_W-1:0]    debounce_ticks;
    logic [CFG_W-1:0]    min_half_cycle;
    logic [CFG_W-1:0]    max_half_cycle;
    logic [CFG_W-1:0]    min_fire_delay;
    logic [CFG_W-1:0]    gate_pulse_width;
    logic [OFFSET_W-1:0] fire_offset;
  } cfg_t;

  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    logic [AVG_W-1:0]    avg;
  } delay_req_t;

  typedef struct packed {
    logic [CFG_W-1:0] delay;
  } delay_rsp_t;

  // (100 - pct) * ceil(2^30/100); pct is already clamped to 100
  function automatic logic [FACTOR_W-1:0] pct_factor(input logic [PCT_W-1:0] pct);
    logic [PCT_W-1:0] inv;
    inv = PCT_FULL - pct;
    return FACTOR_W'(inv * RECIP_100);
  endfunction

endpackage

// ----- rtl/core/zcpd_if.sv -----
// Channel interfaces of the zero-cross phase dimmer: ticks, results, config.
// Depends on zcpd_pkg for field widths.
`timescale 1ns / 1ps

interface zcpd_tick_if;
  logic                        valid;
  logic                        ready;
  logic                        zc_level;
  logic [zcpd_pkg::PCT_W-1:0]  brightness;
  modport source (output valid, zc_level, brightness, input ready);
  modport sink   (input valid, zc_level, brightness, output ready);
endinterface

interface zcpd_result_if;
  logic                              valid;
  logic                              ready;
  logic                              gate_drive;
  logic                              crossing_accepted;
  logic [zcpd_pkg::AVG_W-1:0]        half_cycle_estimate;
  logic [zcpd_pkg::RESULT_CNT_W-1:0] accepted_crossings;
  logic [zcpd_pkg::RESULT_CNT_W-1:0] gate_pulses;
  modport source (output valid, gate_drive, crossing_accepted, half_cycle_estimate,
                  accepted_crossings, gate_pulses, input ready);
  modport sink   (input valid, gate_drive, crossing_accepted, half_cycle_estimate,
                  accepted_crossings, gate_pulses, output ready);
endinterface

interface zcpd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [zcpd_pkg::INDEX_W-1:0] index;
  logic [zcpd_pkg::CFG_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/zcpd_cfg_regs.sv -----
// Configuration register file with precomputed firing offset.
// Depends on zcpd_pkg and zcpd_cfg_if.
`timescale 1ns / 1ps

module zcpd_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  zcpd_cfg_if.sink         cfg,
  output zcpd_pkg::cfg_t   cfg_regs
);

  logic                          trigger_level;
  logic [zcpd_pkg::CFG_W-1:0]    debounce_ticks;
  logic [zcpd_pkg::CFG_W-1:0]    min_half_cycle;
  logic [zcpd_pkg::CFG_W-1:0]    max_half_cycle;
  logic [zcpd_pkg::CFG_W-1:0]    min_fire_delay;
  logic [zcpd_pkg::CFG_W-1:0]    end_guard;
  logic [zcpd_pkg::CFG_W-1:0]    gate_pulse_width;
  logic [zcpd_pkg::OFFSET_W-1:0] fire_offset;
  logic [zcpd_pkg::CFG_W-1:0]    min_fire_delay_next;
  logic [zcpd_pkg::CFG_W-1:0]    end_guard_next;
  logic [zcpd_pkg::CFG_W-1:0]    gate_pulse_width_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_level    <= zcpd_pkg::RST_TRIGGER_LEVEL;
      debounce_ticks   <= zcpd_pkg::RST_DEBOUNCE;
      min_half_cycle   <= zcpd_pkg::RST_MIN_HALF;
      max_half_cycle   <= zcpd_pkg::RST_MAX_HALF;
      min_fire_delay   <= zcpd_pkg::RST_MIN_FIRE;
      end_guard        <= zcpd_pkg::RST_END_GUARD;
      gate_pulse_width <= zcpd_pkg::RST_PULSE_WIDTH;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        zcpd_pkg::CFG_TRIGGER_LEVEL:    trigger_level    <= cfg.data[0];
        zcpd_pkg::CFG_DEBOUNCE_TICKS:   debounce_ticks   <= cfg.data;
        zcpd_pkg::CFG_MIN_HALF_CYCLE:   min_half_cycle   <= cfg.data;
        zcpd_pkg::CFG_MAX_HALF_CYCLE:   max_half_cycle   <= cfg.data;
        zcpd_pkg::CFG_MIN_FIRE_DELAY:   min_fire_delay   <= cfg.data;
        zcpd_pkg::CFG_END_GUARD:        end_guard        <= cfg.data;
        zcpd_pkg::CFG_GATE_PULSE_WIDTH: gate_pulse_width <= cfg.data;
        default: ;  // unknown index ignored
      endcase
    end
  end

  // Offset is built from the values being written, so it never lags the registers
  assign min_fire_delay_next   = (cfg.valid && cfg.index == zcpd_pkg::CFG_MIN_FIRE_DELAY)
                               ? cfg.data : min_fire_delay;
  assign end_guard_next        = (cfg.valid && cfg.index == zcpd_pkg::CFG_END_GUARD)
                               ? cfg.data : end_guard;
  assign gate_pulse_width_next = (cfg.valid && cfg.index == zcpd_pkg::CFG_GATE_PULSE_WIDTH)
                               ? cfg.data : gate_pulse_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      fire_offset <= zcpd_pkg::OFFSET_W'(zcpd_pkg::RST_END_GUARD)
                   + zcpd_pkg::OFFSET_W'(zcpd_pkg::RST_PULSE_WIDTH)
                   + zcpd_pkg::OFFSET_W'(zcpd_pkg::RST_MIN_FIRE);
    end else begin
      fire_offset <= zcpd_pkg::OFFSET_W'(end_guard_next)
                   + zcpd_pkg::OFFSET_W'(gate_pulse_width_next)
                   + zcpd_pkg::OFFSET_W'(min_fire_delay_next);
    end
  end

  assign cfg_regs.trigger_level    = trigger_level;
  assign cfg_regs.debounce_ticks   = debounce_ticks;
  assign cfg_regs.min_half_cycle   = min_half_cycle;
  assign cfg_regs.max_half_cycle   = max_half_cycle;
  assign cfg_regs.min_fire_delay   = min_fire_delay;
  assign cfg_regs.gate_pulse_width = gate_pulse_width;
  assign cfg_regs.fire_offset      = fire_offset;

endmodule

// ----- rtl/core/zcpd_delay_calc.sv -----
// Fire delay datapath: window subtract, reciprocal multiply, offset add.
// Depends on zcpd_pkg.
`timescale 1ns / 1ps

module zcpd_delay_calc (
  input  zcpd_pkg::cfg_t       cfg_regs,
  input  zcpd_pkg::delay_req_t req,
  output zcpd_pkg::delay_rsp_t rsp
);

  logic [zcpd_pkg::AVG_W-1:0]           window;
  logic [zcpd_pkg::PROD_W-1:0]          prod;
  logic signed [zcpd_pkg::WINDOW_W-1:0] window_s;

  assign window_s = signed'(zcpd_pkg::WINDOW_W'(req.avg))
                  - signed'(zcpd_pkg::WINDOW_W'(cfg_regs.fire_offset));

  // non-positive window clamps to zero, giving min_fire_delay
  assign window = (window_s > 0) ? window_s[zcpd_pkg::AVG_W-1:0] : '0;
  assign prod   = zcpd_pkg::PROD_W'(window) * zcpd_pkg::PROD_W'(req.factor);

  assign rsp.delay = zcpd_pkg::CFG_W'(cfg_regs.min_fire_delay
                   + prod[zcpd_pkg::PROD_W-1:zcpd_pkg::RECIP_SHIFT]);

endmodule

// ----- rtl/core/zcpd_tick_core.sv -----
// Per-tick state update: edge detect, debounce, half-cycle average, gate timer.
// Depends on zcpd_pkg.
`timescale 1ns / 1ps

module zcpd_tick_core (
  input  logic                                clk,
  input  logic                                rst,
  input  zcpd_pkg::cfg_t                      cfg_regs,
  input  logic                                fire,
  input  logic                                zc_level,
  input  logic [zcpd_pkg::PCT_W-1:0]          brightness,
  input  zcpd_pkg::delay_rsp_t                dly_rsp,
  output zcpd_pkg::delay_req_t                dly_req,
  output logic                                gate_level,
  output logic                                crossing_flag,
  output logic [zcpd_pkg::AVG_W-1:0]          half_cycle_avg,
  output logic [zcpd_pkg::COUNT_WIDTH-1:0]    crossing_count,
  output logic [zcpd_pkg::COUNT_WIDTH-1:0]    pulse_count
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_FIRE = 2'd1,
    PH_OFF  = 2'd2
  } phase_t;

  logic [zcpd_pkg::ELAPSED_WIDTH-1:0] since_crossing, since_crossing_next;
  logic                               previous_level;
  phase_t                             gate_phase, gate_phase_next;
  logic [zcpd_pkg::CFG_W-1:0]         gate_countdown, gate_countdown_next;
  logic                               gate_level_next;
  logic [zcpd_pkg::AVG_W-1:0]         half_cycle_avg_next;
  logic [zcpd_pkg::COUNT_WIDTH-1:0]   crossing_count_next, pulse_count_next;

  logic [zcpd_pkg::ELAPSED_WIDTH-1:0] elapsed;
  logic [zcpd_pkg::AVG_SUM_W-1:0]     avg_sum;
  logic [zcpd_pkg::PCT_W-1:0]         pct;
  logic                               accept;
  logic                               in_range;
  logic                               schedule;

  always_comb begin
    elapsed  = (since_crossing == zcpd_pkg::ELAPSED_MAX) ? since_crossing
             : since_crossing + 1'b1;
    pct      = (brightness > zcpd_pkg::PCT_FULL) ? zcpd_pkg::PCT_FULL : brightness;
    accept   = (zc_level != previous_level) && (zc_level == cfg_regs.trigger_level)
            && (elapsed >= zcpd_pkg::ELAPSED_WIDTH'(cfg_regs.debounce_ticks));
    in_range = (elapsed >= zcpd_pkg::ELAPSED_WIDTH'(cfg_regs.min_half_cycle))
            && (elapsed <= zcpd_pkg::ELAPSED_WIDTH'(cfg_regs.max_half_cycle));
    // 7*avg + elapsed, then /8
    avg_sum  = zcpd_pkg::AVG_SUM_W'({half_cycle_avg, 3'b000})
             - zcpd_pkg::AVG_SUM_W'(half_cycle_avg)
             + zcpd_pkg::AVG_SUM_W'(elapsed);
    schedule = accept && (pct != '0);
    half_cycle_avg_next = (accept && in_range) ? avg_sum[zcpd_pkg::AVG_W+2:3]
                        : half_cycle_avg;
  end

  // the delay uses the average as updated by this crossing
  assign dly_req.factor = zcpd_pkg::pct_factor(pct);
  assign dly_req.avg    = half_cycle_avg_next;

  always_comb begin
    since_crossing_next = elapsed;
    crossing_count_next = crossing_count;
    pulse_count_next    = pulse_count;
    gate_level_next     = gate_level;
    gate_phase_next     = gate_phase;
    gate_countdown_next = gate_countdown;

    if (accept) begin
      since_crossing_next = '0;
      crossing_count_next = crossing_count + 1'b1;
      gate_level_next     = 1'b0;
      gate_phase_next     = schedule ? PH_FIRE : PH_IDLE;
      gate_countdown_next = schedule ? dly_rsp.delay : '0;
    end else begin
      unique case (gate_phase)
        PH_FIRE: begin
          if (gate_countdown > 1) begin
            gate_countdown_next = gate_countdown - 1'b1;
          end else begin
            gate_level_next     = 1'b1;
            pulse_count_next    = pulse_count + 1'b1;
            gate_phase_next     = PH_OFF;
            gate_countdown_next = cfg_regs.gate_pulse_width;
          end
        end
        PH_OFF: begin
          if (gate_countdown > 1) begin
            gate_countdown_next = gate_countdown - 1'b1;
          end else begin
            gate_level_next     = 1'b0;
            gate_phase_next     = PH_IDLE;
            gate_countdown_next = '0;
          end
        end
        default: ;  // idle and the unused code hold
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      since_crossing <= '0;
      half_cycle_avg <= zcpd_pkg::DEFAULT_HALF_CYCLE;
      previous_level <= 1'b1;
      gate_phase     <= PH_IDLE;
      gate_countdown <= '0;
      gate_level     <= 1'b0;
      crossing_count <= '0;
      pulse_count    <= '0;
      crossing_flag  <= 1'b0;
    end else if (fire) begin
      since_crossing <= since_crossing_next;
      half_cycle_avg <= half_cycle_avg_next;
      previous_level <= zc_level;
      gate_phase     <= gate_phase_next;
      gate_countdown <= gate_countdown_next;
      gate_level     <= gate_level_next;
      crossing_count <= crossing_count_next;
      pulse_count    <= pulse_count_next;
      crossing_flag  <= accept;
    end
  end

endmodule

// ----- rtl/core/zero_cross_phase_dimmer_top.sv -----
// Top level of the zero-cross phase-angle dimmer.
// Depends on zcpd_pkg, zcpd_if, zcpd_cfg_regs, zcpd_delay_calc, zcpd_tick_core.
//
// Usage:
//  - tick: one transfer per timer tick, carrying the sampled zero-cross pin
//    level and a brightness percent (values above 100 act as 100).
//  - result: one transfer per tick: gate level, crossing flag, half-cycle
//    average and the two wrapping event counters, all as of after that tick.
//  - cfg: register writes (index, data), always ready; write only while idle.
//  - Path: a transferred tick is captured in the input register, then
//    processed into the state registers, from which its result transfers.
//  - Throughput: one tick per cycle, back to back, unless results stall.
//    A crossing's fire delay (window subtract, 16x30 reciprocal multiply,
//    offset add) is made in the same cycle as its tick; crossings cost no gap.
//  - Reset (rst, synchronous): config returns to its defaults, average to
//    10000 ticks, previous pin level to high, gate idle, counters zero.
//  - Receiver stall: the result is held in the state registers; one more
//    tick waits in the input register, then tick.ready drops.
`timescale 1ns / 1ps
`include "zero_cross_phase_dimmer_top_defines.svh"

module zero_cross_phase_dimmer_top (
  input  logic          clk,
  input  logic          rst,
  zcpd_cfg_if.sink      cfg,
  zcpd_tick_if.sink     tick,
  zcpd_result_if.source result
);

  zcpd_pkg::cfg_t       cfg_regs;
  zcpd_pkg::delay_req_t dly_req;
  zcpd_pkg::delay_rsp_t dly_rsp;

  // input register
  logic                       in_valid;
  logic                       in_zc_level;
  logic [zcpd_pkg::PCT_W-1:0] in_brightness;

  logic out_valid;
  logic proc_fire;

  logic                             gate_level;
  logic                             crossing_flag;
  logic [zcpd_pkg::AVG_W-1:0]       half_cycle_avg;
  logic [zcpd_pkg::COUNT_WIDTH-1:0] crossing_count;
  logic [zcpd_pkg::COUNT_WIDTH-1:0] pulse_count;

  // Process the held tick when the result slot is free or being emptied
  // this cycle.
  assign proc_fire  = in_valid && (!out_valid || result.ready);
  assign tick.ready = !in_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_zc_level   <= tick.zc_level;
      in_brightness <= tick.brightness;
    end
  end

  // State registers double as the result register: they only move on
  // proc_fire, which needs the previous result gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  zcpd_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cfg_regs (cfg_regs)
  );

  zcpd_tick_core u_tick_core (
    .clk            (clk),
    .rst            (rst),
    .cfg_regs       (cfg_regs),
    .fire           (proc_fire),
    .zc_level       (in_zc_level),
    .brightness     (in_brightness),
    .dly_rsp        (dly_rsp),
    .dly_req        (dly_req),
    .gate_level     (gate_level),
    .crossing_flag  (crossing_flag),
    .half_cycle_avg (half_cycle_avg),
    .crossing_count (crossing_count),
    .pulse_count    (pulse_count)
  );

  zcpd_delay_calc u_delay_calc (
    .cfg_regs (cfg_regs),
    .req      (dly_req),
    .rsp      (dly_rsp)
  );

  assign result.valid               = out_valid;
  assign result.gate_drive          = gate_level;
  assign result.crossing_accepted   = crossing_flag;
  assign result.half_cycle_estimate = half_cycle_avg;
  assign result.accepted_crossings  = zcpd_pkg::RESULT_CNT_W'(crossing_count);
  assign result.gate_pulses         = zcpd_pkg::RESULT_CNT_W'(pulse_count);

  // an empty input register always takes a tick
  `ZCPD_ASSERT_NOW(a_ready_when_empty, !in_valid, tick.ready)
  // an accepted crossing always leaves the gate low
  `ZCPD_ASSERT_NOW(a_cross_gate_low, result.valid && result.crossing_accepted,
                   !result.gate_drive)
  // a stalled result stays put
  `ZCPD_ASSERT_NEXT(a_result_hold, result.valid && !result.ready,
                    result.valid && $stable(result.accepted_crossings))

endmodule
